>>> rtl/core/mlpt_pkg.sv
// ----------------------------------------------------------------------------
// mlpt_pkg
// Types and constants of the multilevel page table: request and result words,
// command and status codes, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package mlpt_pkg;

	localparam int ADDRESS_BITS = 32;
	localparam int FRAME_BITS   = 24;
	localparam int IDX_MAX_BITS = 16;
	localparam int WIDTH_REGS   = 4;
	localparam int ENTRY_W      = FRAME_BITS + 1;
	localparam int PTR_W        = FRAME_BITS + 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;
	localparam int LEVELS_W   = 3;
	localparam int WBITS_W    = 5;

	localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BITS0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BITS1  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BITS2  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BITS3  = 3'd4;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	localparam logic [2:0] ST_MISS     = 3'd0;
	localparam logic [2:0] ST_HIT      = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_MAPPED   = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_BAD      = 3'd5;

	typedef struct packed {
		logic                    command;
		logic [ADDRESS_BITS-1:0] logical_address;
		logic [FRAME_BITS-1:0]   frame_number;
	} request_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [FRAME_BITS-1:0] frame_found;
	} result_t;

endpackage

>>> rtl/core/multilevel_page_table.sv
// ----------------------------------------------------------------------------
// multilevel_page_table
// Radix page table walker over one entry store: lookup walks the levels one
// read at a time, insert carves and clears missing nodes in order.
// ----------------------------------------------------------------------------
// a request runs from accept to the done strobe over the L levels in use, reading
// R of them (R = L on a full walk); bad level widths are answered without a walk
// an allocating insert clears all 2^bits words of each new node, since every
// new entry is cleared through the single store write port one word at a time
// busy stays high until the done strobe, so the next word is taken in that cycle
// after reset every store word is swept clear with busy high
module multilevel_page_table #(
	parameter int MAX_LEVELS  = 4,
	parameter int ENTRY_WORDS = 65536
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  mlpt_pkg::request_t                   request,
	output logic                                 done,
	output mlpt_pkg::result_t                    result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mlpt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mlpt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import mlpt_pkg::*;

	localparam int LEVEL_CAP = (MAX_LEVELS < WIDTH_REGS) ? MAX_LEVELS : WIDTH_REGS;
	localparam int IW        = (LEVEL_CAP > 1) ? $clog2(LEVEL_CAP) : 1;
	localparam int AW        = $clog2(ENTRY_WORDS);
	localparam int CW        = $clog2(ENTRY_WORDS + 1);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_INDEX = 4'd3;
	localparam logic [3:0] S_WADDR = 4'd4;
	localparam logic [3:0] S_WDATA = 4'd5;
	localparam logic [3:0] S_ALLOC = 4'd6;
	localparam logic [3:0] S_ZERO  = 4'd7;
	localparam logic [3:0] S_LINK  = 4'd8;

	// configuration
	logic [LEVELS_W-1:0] levels_q;
	logic [WBITS_W-1:0]  bits_q [WIDTH_REGS];

	// sequencer
	logic [3:0]          state_q;
	logic [LEVELS_W-1:0] lv_q;
	logic [LEVELS_W-1:0] d_q;
	logic [LEVELS_W-1:0] miss_q;
	logic [5:0]          run_sum_q;
	logic [CW-1:0]       nf_q;
	logic [PTR_W-1:0]    clr_q;
	logic [PTR_W-1:0]    alloc_q;
	logic [PTR_W-1:0]    base_q;
	logic [PTR_W-1:0]    slot_q;
	logic [IDX_MAX_BITS-1:0] idx_q [LEVEL_CAP];
	request_t            req_q;
	result_t             res_q;
	logic                done_q;

	// entry store
	logic [ENTRY_W-1:0]  mem [ENTRY_WORDS];
	logic [ENTRY_W-1:0]  rd_q;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [ENTRY_W-1:0]  wdata;
	logic                re;
	logic [AW-1:0]       raddr;

	// datapath
	logic                ins;
	logic [WBITS_W-1:0]  cur_w;
	logic [IDX_MAX_BITS-1:0] cur_idx;
	logic [5:0]          shamt;
	logic [IDX_MAX_BITS-1:0] idx_val;
	logic [PTR_W-1:0]    slot;
	logic                slot_oob;
	logic                rd_valid;
	logic [FRAME_BITS-1:0] rd_payload;
	logic                is_leaf;
	logic                last_level;
	logic [PTR_W-1:0]    root_size;
	logic [PTR_W-1:0]    start_ptr;
	logic [PTR_W-1:0]    need;
	logic                full;
	logic [PTR_W-1:0]    node_end;
	logic [6:0]          chk_sum;
	logic                chk_wide;
	logic                bad;
	logic [LEVELS_W-1:0] lv_next;

	assign cfg_ready = 1'b1;
	assign busy      = state_q != S_IDLE;
	assign done      = done_q;
	assign result    = res_q;

	always_comb begin
		if (levels_q == '0) begin
			lv_next = LEVELS_W'(1);
		end else if (levels_q > LEVELS_W'(LEVEL_CAP)) begin
			lv_next = LEVELS_W'(LEVEL_CAP);
		end else begin
			lv_next = levels_q;
		end
	end

	always_comb begin
		ins        = req_q.command == CMD_INSERT;
		cur_w      = bits_q[d_q[1:0]];
		cur_idx    = idx_q[d_q[IW-1:0]];
		shamt      = 6'(ADDRESS_BITS) - (run_sum_q + 6'(cur_w));
		idx_val    = IDX_MAX_BITS'(req_q.logical_address >> shamt)
			& IDX_MAX_BITS'((17'(1) << cur_w) - 17'(1));
		slot       = base_q + PTR_W'(cur_idx);
		slot_oob   = slot >= PTR_W'(ENTRY_WORDS);
		rd_valid   = rd_q[FRAME_BITS];
		rd_payload = rd_q[FRAME_BITS-1:0];
		is_leaf    = d_q == lv_q - LEVELS_W'(1);
		last_level = (d_q + LEVELS_W'(1)) == lv_q;
		root_size  = PTR_W'(1) << bits_q[0];
		start_ptr  = root_size + PTR_W'(nf_q);
		node_end   = alloc_q + (PTR_W'(1) << cur_w);
		need       = '0;
		chk_sum    = '0;
		chk_wide   = 1'b0;
		for (int k = 0; k < WIDTH_REGS; k++) begin
			if (LEVELS_W'(k) < lv_q) begin
				chk_sum = chk_sum + 7'(bits_q[k]);
				if (bits_q[k] > WBITS_W'(IDX_MAX_BITS)) begin
					chk_wide = 1'b1;
				end
				if (LEVELS_W'(k) > miss_q) begin
					need = need + (PTR_W'(1) << bits_q[k]);
				end
			end
		end
		full = (start_ptr + need) > PTR_W'(ENTRY_WORDS);
		bad  = chk_wide || (chk_sum > 7'(ADDRESS_BITS)) || (root_size > PTR_W'(ENTRY_WORDS));
	end

	// store port control
	always_comb begin
		we    = 1'b0;
		waddr = clr_q[AW-1:0];
		wdata = '0;
		re    = 1'b0;
		raddr = slot[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_WADDR: begin
				re = !slot_oob;
			end
			S_WDATA: begin
				if (is_leaf && ins && !rd_valid) begin
					we    = 1'b1;
					waddr = slot_q[AW-1:0];
					wdata = {1'b1, req_q.frame_number};
				end
			end
			S_ALLOC: begin
				if (!full) begin
					we    = 1'b1;
					waddr = slot_q[AW-1:0];
					wdata = {1'b1, start_ptr[FRAME_BITS-1:0]};
				end
			end
			S_ZERO: begin
				we = 1'b1;
			end
			S_LINK: begin
				we    = 1'b1;
				waddr = AW'(alloc_q + PTR_W'(cur_idx));
				wdata = {1'b1, last_level ? req_q.frame_number : node_end[FRAME_BITS-1:0]};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q  <= LEVELS_W'(1);
			bits_q[0] <= WBITS_W'(12);
			bits_q[1] <= WBITS_W'(8);
			bits_q[2] <= WBITS_W'(8);
			bits_q[3] <= WBITS_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEVELS: levels_q  <= cfg_data[LEVELS_W-1:0];
				REG_BITS0:  bits_q[0] <= cfg_data;
				REG_BITS1:  bits_q[1] <= cfg_data;
				REG_BITS2:  bits_q[2] <= cfg_data;
				REG_BITS3:  bits_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= request;
			lv_q  <= lv_next;
		end
		if (state_q == S_INDEX) begin
			idx_q[d_q[IW-1:0]] <= idx_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			nf_q      <= '0;
			done_q    <= 1'b0;
			d_q       <= '0;
			miss_q    <= '0;
			run_sum_q <= '0;
			alloc_q   <= '0;
			base_q    <= '0;
			slot_q    <= '0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + PTR_W'(1);
					if (clr_q == PTR_W'(ENTRY_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						miss_q  <= LEVELS_W'(LEVEL_CAP);
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (bad) begin
						res_q   <= '{status: ST_BAD, frame_found: '0};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						d_q       <= '0;
						run_sum_q <= '0;
						state_q   <= S_INDEX;
					end
				end
				S_INDEX: begin
					run_sum_q <= run_sum_q + 6'(cur_w);
					if (last_level) begin
						d_q     <= '0;
						base_q  <= '0;
						state_q <= S_WADDR;
					end else begin
						d_q <= d_q + LEVELS_W'(1);
					end
				end
				S_WADDR: begin
					slot_q <= slot;
					if (slot_oob) begin
						res_q   <= '{status: ins ? ST_FULL : ST_MISS, frame_found: '0};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WDATA;
					end
				end
				S_WDATA: begin
					if (is_leaf) begin
						if (!ins) begin
							res_q <= '{status: rd_valid ? ST_HIT : ST_MISS,
								frame_found: rd_valid ? rd_payload : '0};
						end else begin
							res_q <= '{status: rd_valid ? ST_MAPPED : ST_INSERTED,
								frame_found: '0};
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (!rd_valid) begin
						miss_q <= d_q;
						if (ins) begin
							state_q <= S_ALLOC;
						end else begin
							res_q   <= '{status: ST_MISS, frame_found: '0};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						base_q  <= PTR_W'(rd_payload);
						d_q     <= d_q + LEVELS_W'(1);
						state_q <= S_WADDR;
					end
				end
				S_ALLOC: begin
					if (full) begin
						res_q   <= '{status: ST_FULL, frame_found: '0};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						alloc_q <= start_ptr;
						clr_q   <= start_ptr;
						d_q     <= miss_q + LEVELS_W'(1);
						state_q <= S_ZERO;
					end
				end
				S_ZERO: begin
					clr_q <= clr_q + PTR_W'(1);
					if (clr_q == node_end - PTR_W'(1)) begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					alloc_q <= node_end;
					clr_q   <= node_end;
					if (last_level) begin
						nf_q    <= CW'(node_end - root_size);
						res_q   <= '{status: ST_INSERTED, frame_found: '0};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						d_q     <= d_q + LEVELS_W'(1);
						state_q <= S_ZERO;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer still busy");

	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_HIT) |-> result.frame_found == '0)
		else $error("nonzero frame on a result that is not a hit");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= CW'(ENTRY_WORDS))
		else $error("allocation counter beyond store depth");

endmodule
